// ----- design/lsrr_pkg.sv -----
`timescale 1ns / 1ps

package lsrr_pkg;

    localparam int WORD_W    = 15;
    localparam int LAG_DEPTH = 4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [1:0]        mode_t;

    localparam mode_t MODE_SINGLE = 2'd0;
    localparam mode_t MODE_MIN    = 2'd1;
    localparam mode_t MODE_RESEED = 2'd2;

    localparam word_t WORD_MAX  = 15'd32767;
    localparam word_t RANGE_SAT = 15'd32766;

    localparam word_t LAG_INIT [LAG_DEPTH] = '{15'd1018, 15'd4521, 15'd202, 15'd419};

    typedef struct packed {
        logic  advance;
        logic  reseed;
        word_t seed;
    } lag_cmd_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quotient;
    } div_rsp_t;

endpackage

// ----- design/lsrr_div.sv -----
`timescale 1ns / 1ps

module lsrr_div
    import lsrr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [3:0] LAST_STEP = 4'(WORD_W - 1);

    logic            busy_reg;
    logic            done_reg;
    logic [3:0]      cnt_reg;
    word_t           rem_reg;
    word_t           quo_reg;
    word_t           dsr_reg;

    logic [WORD_W:0] trial;
    logic            ge;
    logic [WORD_W:0] diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[WORD_W-1]};
        ge    = trial >= {1'b0, dsr_reg};
        diff  = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- design/lsrr_lag.sv -----
`timescale 1ns / 1ps

module lsrr_lag
    import lsrr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  lag_cmd_t cmd,
    output word_t    sum
);

    word_t             words_reg [LAG_DEPTH];
    logic [WORD_W+1:0] sum_full;

    always_comb
    begin
        sum_full = '0;
        for (int i = 0; i < LAG_DEPTH; i++)
        begin
            sum_full = sum_full + (WORD_W+2)'(words_reg[i]);
        end
    end

    assign sum = sum_full[WORD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAG_DEPTH; i++)
            begin
                words_reg[i] <= LAG_INIT[i];
            end
        end
        else if (cmd.advance)
        begin
            for (int i = LAG_DEPTH - 1; i > 0; i--)
            begin
                words_reg[i] <= words_reg[i-1];
            end
            words_reg[0] <= sum;
        end
        else if (cmd.reseed)
        begin
            words_reg[0] <= cmd.seed;
        end
    end

endmodule

// ----- design/lagged_sum_random_ranged_core.sv -----
`timescale 1ns / 1ps
// Sequence: a single draw runs the scale division, then one draw division, then ST_FIN;
// a minimum of two draws runs two draw divisions; reseed and unused mode go to ST_FIN.
// One transaction at a time: in_stall holds input off until the block is back in ST_IDLE;
// the shared one-bit-per-cycle divider serves the scale divisor once and each draw once.
// Reset: asynchronous, active low; lag words return to 1018, 4521, 202, 419.

module lagged_sum_random_ranged_core
    import lsrr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  mode_t mode,
    input  word_t range_limit,
    input  word_t seed_value,
    output logic  out_valid,
    input  logic  out_stall,
    output word_t drawn_value
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVR,
        ST_DRAW,
        ST_FIN
    } state_t;

    state_t   state_reg,     state_next;
    mode_t    mode_reg,      mode_next;
    word_t    range_reg,     range_next;
    word_t    dsr_reg,       dsr_next;
    word_t    first_reg,     first_next;
    logic     pass_reg,      pass_next;
    word_t    result_reg,    result_next;
    logic     out_valid_reg, out_valid_next;
    word_t    drawn_reg,     drawn_next;

    div_req_t div_req;
    div_rsp_t div_rsp;
    lag_cmd_t lag_cmd;
    word_t    lag_sum;

    word_t    range_sat;
    word_t    q_clamp;
    logic     in_accept;

    lsrr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lsrr_lag u_lag (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (lag_cmd),
        .sum   (lag_sum)
    );

    assign in_stall    = state_reg != ST_IDLE;
    assign in_accept   = in_valid && !in_stall;
    assign range_sat   = (range_limit > RANGE_SAT) ? RANGE_SAT : range_limit;
    assign q_clamp     = (div_rsp.quotient > range_reg) ? range_reg : div_rsp.quotient;
    assign out_valid   = out_valid_reg;
    assign drawn_value = drawn_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        range_next     = range_reg;
        dsr_next       = dsr_reg;
        first_next     = first_reg;
        pass_next      = pass_reg;
        result_next    = result_reg;
        drawn_next     = drawn_reg;
        out_valid_next = out_valid_reg && out_stall;

        div_req.start    = 1'b0;
        div_req.dividend = lag_sum;
        div_req.divisor  = dsr_reg;
        lag_cmd.advance  = 1'b0;
        lag_cmd.reseed   = 1'b0;
        lag_cmd.seed     = seed_value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next   = mode;
                    range_next  = range_sat;
                    pass_next   = 1'b0;
                    result_next = '0;
                    unique case (mode)
                        MODE_SINGLE, MODE_MIN:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = WORD_MAX;
                            div_req.divisor  = range_sat + 15'd1;
                            state_next       = ST_DIVR;
                        end
                        MODE_RESEED:
                        begin
                            lag_cmd.reseed = 1'b1;
                            state_next     = ST_FIN;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_DIVR:
            begin
                if (div_rsp.done)
                begin
                    dsr_next         = div_rsp.quotient;
                    div_req.start    = 1'b1;
                    div_req.divisor  = div_rsp.quotient;
                    lag_cmd.advance  = 1'b1;
                    state_next       = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (div_rsp.done)
                begin
                    if (mode_reg == MODE_MIN && !pass_reg)
                    begin
                        first_next      = q_clamp;
                        pass_next       = 1'b1;
                        div_req.start   = 1'b1;
                        lag_cmd.advance = 1'b1;
                    end
                    else
                    begin
                        if (mode_reg == MODE_MIN && first_reg < q_clamp)
                        begin
                            result_next = first_reg;
                        end
                        else
                        begin
                            result_next = q_clamp;
                        end
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    drawn_next     = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            drawn_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
            drawn_reg     <= drawn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        range_reg  <= range_next;
        dsr_reg    <= dsr_next;
        first_reg  <= first_next;
        result_reg <= result_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIVR || state_reg == ST_DRAW))
        else $error("divider finished outside a draw");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVR && div_rsp.done) |-> div_rsp.quotient != '0)
        else $error("scale divisor is zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> result_reg <= range_reg)
        else $error("result exceeds range");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != ST_IDLE)
        else $error("accepted transaction not started");

    assert property (@(posedge clk) disable iff (!rst_n)
        (lag_cmd.advance && lag_cmd.reseed) |-> 1'b0)
        else $error("advance and reseed together");

endmodule

// ----- sim/lsrr_draw_checker.sv -----
`timescale 1ns / 1ps

module lsrr_draw_checker
    import lsrr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_stall,
    input  mode_t mode,
    input  word_t range_limit,
    input  word_t seed_value,
    input  logic  out_valid,
    input  logic  out_stall,
    input  word_t drawn_value,
    output int    mismatches,
    output int    draws_pending
);

    word_t lag_state [LAG_DEPTH];
    word_t expected_draws [$];

    // advance the lag words once and scale the new sum into 0..rng
    function automatic word_t scaled_draw(input word_t rng);
        int unsigned sum;
        int unsigned divisor;
        int unsigned quot;
        int          i;
        sum = 0;
        for (i = 0; i < LAG_DEPTH; i++)
        begin
            sum += 32'(lag_state[i]);
        end
        sum &= 32'(WORD_MAX);
        for (i = LAG_DEPTH - 1; i > 0; i--)
        begin
            lag_state[i] = lag_state[i - 1];
        end
        lag_state[0] = word_t'(sum);
        divisor = 32'(WORD_MAX) / (32'(rng) + 1);
        if (divisor == 0)
        begin
            divisor = 1;
        end
        quot = sum / divisor;
        if (quot > 32'(rng))
        begin
            quot = 32'(rng);
        end
        return word_t'(quot);
    endfunction

    function automatic word_t predict_draw(input mode_t m, input word_t r, input word_t s);
        word_t rng;
        word_t first;
        word_t second;
        rng = (r > RANGE_SAT) ? RANGE_SAT : r;
        case (m)
            MODE_SINGLE:
            begin
                return scaled_draw(rng);
            end
            MODE_MIN:
            begin
                first  = scaled_draw(rng);
                second = scaled_draw(rng);
                return (first < second) ? first : second;
            end
            MODE_RESEED:
            begin
                lag_state[0] = s;
                return '0;
            end
            default:
            begin
                return '0;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        word_t want;
        if (!rst_n)
        begin
            lag_state = LAG_INIT;
            expected_draws.delete();
            mismatches = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_draws.push_back(predict_draw(mode, range_limit, seed_value));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_draws.size() == 0)
                begin
                    $error("drawn_value with no transaction pending: actual %0d", drawn_value);
                    mismatches++;
                end
                else
                begin
                    want = expected_draws.pop_front();
                    if (drawn_value !== want)
                    begin
                        $error("drawn_value mismatch: expected %0d, actual %0d",
                               want, drawn_value);
                        mismatches++;
                    end
                end
            end
        end
        draws_pending = expected_draws.size();
    end

endmodule

// ----- sim/lagged_sum_random_ranged_core_tb.sv -----
`timescale 1ns / 1ps

module lagged_sum_random_ranged_core_tb;
    import lsrr_pkg::*;

    localparam int    ITEM_COUNT  = 600;
    localparam int    IDLE_LIMIT  = 5000;
    localparam int    HOLD_AT     = 2000;
    localparam int    HOLD_LEN    = 600;
    localparam int    DRAIN_WAIT  = 60;
    localparam mode_t MODE_UNUSED = 2'd3;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    mode_t mode;
    word_t range_limit;
    word_t seed_value;
    logic  out_valid;
    logic  out_stall;
    word_t drawn_value;

    int mismatches;
    int draws_pending;
    int sent_count;
    int idle_cycles;

    lagged_sum_random_ranged_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .range_limit (range_limit),
        .seed_value  (seed_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drawn_value (drawn_value)
    );

    lsrr_draw_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .range_limit   (range_limit),
        .seed_value    (seed_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drawn_value   (drawn_value),
        .mismatches    (mismatches),
        .draws_pending (draws_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic offer(input mode_t m, input word_t r, input word_t s);
        in_valid    <= 1'b1;
        mode        <= m;
        range_limit <= r;
        seed_value  <= s;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent_count++;
        @(negedge clk);
    endtask

    task automatic offer_random();
        int    pick;
        mode_t m;
        word_t r;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            m = MODE_SINGLE;
        else if (pick < 14)
            m = MODE_MIN;
        else if (pick < 18)
            m = MODE_RESEED;
        else
            m = MODE_UNUSED;
        case ($urandom_range(0, 7))
            0, 1:    r = word_t'($urandom_range(0, 32767));
            2:
            begin
                case ($urandom_range(0, 2))
                    0:       r = '0;
                    1:       r = RANGE_SAT;
                    default: r = WORD_MAX;
                endcase
            end
            3, 4:    r = word_t'($urandom_range(0, 7));
            default: r = word_t'($urandom_range(0, 1023));
        endcase
        offer(m, r, word_t'($urandom_range(0, 32767)));
    endtask

    initial
    begin
        int burst;
        int gap;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_SINGLE;
        range_limit = '0;
        seed_value  = '0;
        sent_count  = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        offer(MODE_SINGLE, '0, '0);
        offer(MODE_SINGLE, WORD_MAX, WORD_MAX);
        offer(MODE_SINGLE, RANGE_SAT, '0);
        offer(MODE_SINGLE, 15'd1, '0);
        offer(MODE_MIN, '0, '0);
        offer(MODE_MIN, WORD_MAX, '0);
        offer(MODE_MIN, 15'd100, '0);
        offer(MODE_RESEED, '0, '0);
        offer(MODE_SINGLE, RANGE_SAT, '0);
        offer(MODE_RESEED, WORD_MAX, WORD_MAX);
        offer(MODE_RESEED, 15'h5555, 15'h2aaa);
        offer(MODE_SINGLE, WORD_MAX, '0);
        offer(MODE_UNUSED, WORD_MAX, WORD_MAX);
        offer(MODE_UNUSED, '0, '0);
        offer(MODE_SINGLE, WORD_MAX, '0);
        offer(MODE_MIN, RANGE_SAT, WORD_MAX);
        offer(MODE_SINGLE, 15'h2aaa, 15'h5555);
        in_valid <= 1'b0;
        repeat (5) @(negedge clk);

        while (sent_count < ITEM_COUNT)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                offer_random();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b0;

        while (draws_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int rx_cycles;
        int phase;
        int span;
        bit held;
        out_stall = 1'b0;
        rx_cycles = 0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && rx_cycles >= HOLD_AT)
            begin
                // hold off long enough that the block fills and stalls its input
                held = 1'b1;
                repeat (HOLD_LEN)
                begin
                    @(negedge clk);
                    rx_cycles++;
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                phase = $urandom_range(0, 3);
                span  = $urandom_range(5, 60);
                repeat (span)
                begin
                    @(negedge clk);
                    rx_cycles++;
                    case (phase)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= ($urandom_range(0, 1) == 0);
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
        else
        begin
            idle_cycles = 0;
        end
    end

endmodule
